@@ rtl/rotenc_pkg.sv @@
// Package with types and constants of the rotary encoder position counter.
`default_nettype none
package rotenc_pkg;

	localparam int unsigned DEBOUNCE_W = 32;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned TS_W       = 32;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_USER_W = 5;

	localparam logic [DEBOUNCE_W-1:0] RESET_DEBOUNCE  = 32'd1500;
	localparam logic [COUNT_W-1:0]    RESET_COUNT_MAX = 8'd255;
	localparam logic [COUNT_W-1:0]    RESET_COUNT     = 8'd47;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX = 8'd1;

	typedef enum logic [1:0] {
		SRC_BUTTON = 2'd0,
		SRC_CLK    = 2'd1,
		SRC_DT     = 2'd2,
		SRC_OTHER  = 2'd3
	} src_t;

	typedef enum logic [1:0] {
		MOVE_NONE = 2'd0,
		MOVE_UP   = 2'd1,
		MOVE_DOWN = 2'd2
	} move_t;

	typedef struct packed {
		logic [COUNT_W-1:0] position;
		logic               button_event;
		logic               accepted;
		move_t              movement;
		logic               at_limit;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/rotary_encoder_debounced_counter_core.sv @@
// Top level of the debounced rotary encoder position counter.
// The input register and then the result register lie between an accepted request and its result.
// Throughput: one request per cycle unless the result stalls; one subtract, compares, +1 or -1.
// A stalled result holds the pipeline while the input register waits behind it.
// Reset: debounce 1500 us, count limit 255, count 47, stored timestamp and pin levels zero.
`default_nettype none
module rotary_encoder_debounced_counter_core #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// Bits from low: time_us[31:0], clk_level, dt_level, zero fill.
	input  wire logic [rotenc_pkg::IN_DATA_W-1:0]      s_tdata,
	// Bits from low: event_source[1:0].
	input  wire logic [1:0]                            s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// Bits from low: position[7:0].
	output logic [rotenc_pkg::COUNT_W-1:0]             m_tdata,
	// Bits from low: button_event, accepted, movement[1:0], at_limit.
	output logic [rotenc_pkg::OUT_USER_W-1:0]          m_tuser,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [rotenc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rotenc_pkg::DEBOUNCE_W-1:0]     cfg_data
);
	import rotenc_pkg::*;

	logic                   valid_s1;
	src_t                   src_s1;
	logic [TS_W-1:0]        time_s1;
	logic                   clk_lvl_s1;
	logic                   dt_lvl_s1;
	logic                   adv;

	logic [DEBOUNCE_W-1:0]  debounce_q;
	logic [COUNT_W-1:0]     count_max_q;
	logic [TIME_BITS-1:0]   last_time_q;
	logic                   last_clk_q;
	logic                   last_dt_q;
	logic [COUNT_W-1:0]     count_q;

	result_t                res;
	result_t                res_s2;
	logic                   valid_s2;
	logic [TIME_BITS-1:0]   now_time;

	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= RESET_DEBOUNCE;
			count_max_q <= RESET_COUNT_MAX;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DEBOUNCE) begin
				debounce_q <= cfg_data;
			end else if (cfg_index == REG_COUNT_MAX) begin
				count_max_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			src_s1     <= src_t'(s_tuser);
			time_s1    <= s_tdata[TS_W-1:0];
			clk_lvl_s1 <= s_tdata[TS_W];
			dt_lvl_s1  <= s_tdata[TS_W+1];
		end
	end

	rotenc_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.event_source(src_s1),
		.time_us     (time_s1),
		.clk_level   (clk_lvl_s1),
		.dt_level    (dt_lvl_s1),
		.last_time   (last_time_q),
		.last_clk    (last_clk_q),
		.last_dt     (last_dt_q),
		.count       (count_q),
		.debounce_us (debounce_q),
		.count_max   (count_max_q),
		.result      (res),
		.now_time    (now_time)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			last_clk_q  <= 1'b0;
			last_dt_q   <= 1'b0;
			count_q     <= RESET_COUNT;
		end else if (adv) begin
			count_q <= res.position;
			if (res.accepted) begin
				last_time_q <= now_time;
				last_clk_q  <= clk_lvl_s1;
				last_dt_q   <= dt_lvl_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.position;
	assign m_tuser  = {res_s2.at_limit, res_s2.movement, res_s2.accepted, res_s2.button_event};

	a_up_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res.movement == MOVE_UP) |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("Up movement did not raise the count by one.");

	a_reject_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !res.accepted |=> $stable(last_time_q) && $stable(count_q))
		else $error("A request that was not taken changed the debounce state.");

	a_limit_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tuser[3:2] == MOVE_NONE && m_tuser[1])
		else $error("A blocked step reported movement or was not taken.");

	a_button_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[4])
		else $error("A button request was also flagged as an encoder edge.");

endmodule
`default_nettype wire

@@ rtl/rotenc_step.sv @@
// Combinational decision logic for one pin event: debounce, edge detect, saturating count.
`default_nettype none
module rotenc_step #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire rotenc_pkg::src_t                    event_source,
	input  wire logic [rotenc_pkg::TS_W-1:0]         time_us,
	input  wire logic                                clk_level,
	input  wire logic                                dt_level,
	input  wire logic [TIME_BITS-1:0]                last_time,
	input  wire logic                                last_clk,
	input  wire logic                                last_dt,
	input  wire logic [rotenc_pkg::COUNT_W-1:0]      count,
	input  wire logic [rotenc_pkg::DEBOUNCE_W-1:0]   debounce_us,
	input  wire logic [rotenc_pkg::COUNT_W-1:0]      count_max,
	output rotenc_pkg::result_t                      result,
	output logic [TIME_BITS-1:0]                     now_time
);
	import rotenc_pkg::*;

	localparam int unsigned CMP_W = (TIME_BITS > DEBOUNCE_W) ? TIME_BITS : DEBOUNCE_W;

	logic [CMP_W-1:0]     time_ext;
	logic [TIME_BITS-1:0] elapsed;
	logic                 is_clk;
	logic                 is_dt;
	logic                 edge_ok;
	logic                 up_req;
	logic                 dn_req;
	logic                 up_ok;
	logic                 dn_ok;

	assign time_ext = CMP_W'(time_us);
	assign now_time = time_ext[TIME_BITS-1:0];
	assign elapsed  = now_time - last_time;
	assign is_clk   = (event_source == SRC_CLK);
	assign is_dt    = (event_source == SRC_DT);
	assign edge_ok  = CMP_W'(elapsed) > CMP_W'(debounce_us);
	assign up_req   = is_clk && (clk_level != last_clk) && !clk_level && dt_level;
	assign dn_req   = is_dt && (dt_level != last_dt) && !dt_level && clk_level;
	assign up_ok    = count < count_max;
	assign dn_ok    = count != '0;

	always_comb begin
		result              = '0;
		result.position     = count;
		result.movement     = MOVE_NONE;
		result.button_event = (event_source == SRC_BUTTON);
		if ((is_clk || is_dt) && edge_ok) begin
			result.accepted = 1'b1;
			if (up_req) begin
				if (up_ok) begin
					result.position = count + COUNT_W'(1);
					result.movement = MOVE_UP;
				end else begin
					result.at_limit = 1'b1;
				end
			end else if (dn_req) begin
				if (dn_ok) begin
					result.position = count - COUNT_W'(1);
					result.movement = MOVE_DOWN;
				end else begin
					result.at_limit = 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire
